>>> sv/oeas_pkg.sv
// Shared widths, constants and unit request/response types for the one-euro smoother.
`timescale 1ns / 1ps
package oeas_pkg;

  localparam int unsigned RegW     = 24;
  localparam int unsigned MulAW    = 32;
  localparam int unsigned MulBW    = 24;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned MulCntW  = 5;
  localparam int unsigned DivRemW  = 41;
  localparam int unsigned DivLowW  = 32;
  localparam int unsigned DivCntW  = 6;

  // 2*pi with 24 fraction bits, and one million with 8 fraction bits.
  localparam logic [31:0] TwoPiQ24   = 32'd105414357;
  localparam logic [31:0] UsecRateQ8 = 32'd256000000;

  typedef enum logic [1:0] {
    CFG_RATE   = 2'd0,
    CFG_MINCUT = 2'd1,
    CFG_BETA   = 2'd2,
    CFG_DCUT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [MulAW-1:0]   a;
    logic [MulBW-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [ProdW-1:0]   prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DivRemW-1:0] rem;
    logic [DivLowW-1:0] low;
    logic [DivRemW-1:0] den;
    logic [DivCntW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivLowW-1:0] quot;
  } div_rsp_t;

endpackage

>>> sv/oeas_in_if.sv
// Input channel carrying one sample and its optional timestamp.
`timescale 1ns / 1ps
interface oeas_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [31:0]        stamp_us;
  logic               stamp_valid;

  modport source (output valid, sample, stamp_us, stamp_valid, input ready);
  modport sink   (input valid, sample, stamp_us, stamp_valid, output ready);
endinterface

>>> sv/oeas_out_if.sv
// Output channel carrying one smoothed value.
`timescale 1ns / 1ps
interface oeas_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] smoothed;

  modport source (output valid, smoothed, input ready);
  modport sink   (input valid, smoothed, output ready);
endinterface

>>> sv/one_euro_adaptive_smoother.sv
// Top level of the one-euro adaptive smoother: sequencer, state and shared serial units.
//
//   channel   direction  transfer contents
//   in_ch     sink       sample, stamp_us, stamp_valid
//   out_ch    source     smoothed (Q.8)
//   cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i
//
// An item runs at most a 32-step rate division, the derivative
// multiply, two alpha computations (multiply and 17-step division) with their blend
// multiplies, and the cutoff multiply, all run one bit per cycle on a single
// shift-add multiplier and a single restoring divider. Reset is asynchronous and
// active low and restores the register defaults. A result waiting on a stalled
// out_ch does not block the next input transfer; only finishing the next item waits.
`timescale 1ns / 1ps
module one_euro_adaptive_smoother (
  input  logic        clk_i,
  input  logic        rst_ni,
  oeas_in_if.sink     in_ch,
  oeas_out_if.source  out_ch,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RATE = 9'b000000010,
    S_DMUL = 9'b000000100,
    S_DFIL = 9'b000001000,
    S_WMUL = 9'b000010000,
    S_ADIV = 9'b000100000,
    S_BMUL = 9'b001000000,
    S_CMUL = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  state_e             state_q;
  logic               go_q;
  logic               stage_q;     // low for the derivative filter, high for the value filter
  logic [23:0]        min_cut_q;
  logic [23:0]        beta_q;
  logic [23:0]        dcut_q;
  logic [23:0]        cur_rate_q;
  logic [31:0]        prev_stamp_q;
  logic               prev_sv_q;
  logic               vprim_q;
  logic [23:0]        vstate_q;
  logic               dprim_q;
  logic [31:0]        dstate_q;
  logic [23:0]        x_q;
  logic [31:0]        dt_q;
  logic [31:0]        d_q;
  logic [23:0]        fc_q;
  logic [34:0]        w_q;
  logic [40:0]        den_q;
  logic [16:0]        alpha_q;
  logic [31:0]        bmag_q;
  logic               bneg_q;
  logic               out_valid_q;
  logic [23:0]        out_data_q;

  oeas_pkg::mul_req_t mul_req;
  oeas_pkg::mul_rsp_t mul_rsp;
  oeas_pkg::div_req_t div_req;
  oeas_pkg::div_rsp_t div_rsp;

  logic [23:0]        rate_eff;
  logic [31:0]        dt_new;
  logic               upd;
  logic [24:0]        diffx;
  logic               dneg;
  logic [24:0]        dmag;
  logic [31:0]        dsmag;
  logic [55:0]        dround;
  logic [30:0]        dq31;
  logic [31:0]        dval;
  logic [32:0]        s_ext;
  logic [32:0]        v_ext;
  logic [32:0]        bdiff;
  logic [32:0]        babs;
  logic [55:0]        bsum;
  logic [32:0]        bq;
  logic [32:0]        bnew;
  logic [47:0]        csum;
  logic [23:0]        csat;
  logic [23:0]        rsat;
  logic [34:0]        w_new;
  logic [40:0]        den_new;
  logic [51:0]        numer;

  // A rate register written as zero acts as one.
  assign rate_eff = (cur_rate_q == 24'd0) ? 24'd1 : cur_rate_q;

  // Timestamp bookkeeping: dt wraps modulo 2^32, and equal stamps keep the rate.
  assign dt_new = in_ch.stamp_us - prev_stamp_q;
  assign upd    = in_ch.stamp_valid && prev_sv_q && (dt_new != 32'd0);

  // Rounded 1e6/dt in Q.8, held within the 24-bit register range and at least one.
  assign rsat = (div_rsp.quot[31:24] != 8'd0) ? 24'hFFFFFF :
                ((div_rsp.quot[23:0] == 24'd0) ? 24'd1 : div_rsp.quot[23:0]);

  // Raw derivative: (x - last output) * rate / 256, rounded away from zero, saturated.
  assign diffx  = {x_q[23], x_q} - {vstate_q[23], vstate_q};
  assign dneg   = diffx[24];
  assign dmag   = dneg ? (25'd0 - diffx) : diffx;
  assign dround = mul_rsp.prod + 56'd128;
  assign dq31   = (|dround[55:39]) ? 31'h7FFFFFFF : dround[38:8];
  assign dval   = dneg ? (32'd0 - {1'b0, dq31}) : {1'b0, dq31};

  // Magnitude of the smoothed derivative drives the adaptive cutoff.
  assign dsmag = dstate_q[31] ? (32'd0 - dstate_q) : dstate_q;
  assign csum  = {24'd0, min_cut_q} + {1'b0, mul_rsp.prod[54:8]};
  assign csat  = (|csum[47:24]) ? 24'hFFFFFF : csum[23:0];

  // Blend operands: the state being filtered and the new value it moves toward.
  always_comb begin
    if (stage_q) begin
      s_ext = {{9{vstate_q[23]}}, vstate_q};
      v_ext = {{9{x_q[23]}}, x_q};
    end else begin
      s_ext = {dstate_q[31], dstate_q};
      v_ext = {d_q[31], d_q};
    end
  end

  assign bdiff = v_ext - s_ext;
  assign babs  = bdiff[32] ? (33'd0 - bdiff) : bdiff;
  assign bsum  = mul_rsp.prod + 56'd32768;
  assign bq    = bsum[48:16];
  assign bnew  = bneg_q ? (s_ext - bq) : (s_ext + bq);

  // Alpha = w / (w + rate) with w = 2*pi*fc; the quotient never exceeds 2^16.
  assign w_new   = mul_rsp.prod[50:16];
  assign den_new = {6'd0, w_new} + {1'b0, rate_eff, 16'd0};
  assign numer   = {1'b0, w_q, 16'd0} + {12'd0, den_q[40:1]};

  always_comb begin
    mul_req       = '0;
    mul_req.start = go_q && ((state_q == S_DMUL) || (state_q == S_WMUL) ||
                             (state_q == S_BMUL) || (state_q == S_CMUL));
    case (state_q)
      S_DMUL: begin
        mul_req.a = {7'd0, dmag};
        mul_req.b = rate_eff;
      end
      S_WMUL: begin
        mul_req.a = oeas_pkg::TwoPiQ24;
        mul_req.b = fc_q;
      end
      S_BMUL: begin
        mul_req.a = bmag_q;
        mul_req.b = {7'd0, alpha_q};
      end
      S_CMUL: begin
        mul_req.a = dsmag;
        mul_req.b = beta_q;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    div_req       = '0;
    div_req.start = go_q && ((state_q == S_RATE) || (state_q == S_ADIV));
    case (state_q)
      S_RATE: begin
        div_req.rem   = '0;
        div_req.low   = oeas_pkg::UsecRateQ8 + {1'b0, dt_q[31:1]};
        div_req.den   = {9'd0, dt_q};
        div_req.steps = 6'd32;
      end
      S_ADIV: begin
        div_req.rem   = {6'd0, numer[51:17]};
        div_req.low   = {numer[16:0], 15'd0};
        div_req.den   = den_q;
        div_req.steps = 6'd17;
      end
      default: begin
        div_req.rem   = '0;
        div_req.low   = '0;
        div_req.den   = '0;
        div_req.steps = '0;
      end
    endcase
  end

  oeas_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  oeas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequencer. Each unit state starts its unit in the cycle after entry (go_q high)
  // and moves on when the unit reports done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      go_q         <= 1'b0;
      stage_q      <= 1'b0;
      min_cut_q    <= 24'd65536;
      beta_q       <= 24'd459;
      dcut_q       <= 24'd65536;
      cur_rate_q   <= 24'd30720;
      prev_stamp_q <= '0;
      prev_sv_q    <= 1'b0;
      vprim_q      <= 1'b0;
      vstate_q     <= '0;
      dprim_q      <= 1'b0;
      dstate_q     <= '0;
      x_q          <= '0;
      dt_q         <= '0;
      d_q          <= '0;
      fc_q         <= '0;
      w_q          <= '0;
      den_q        <= '0;
      alpha_q      <= '0;
      bmag_q       <= '0;
      bneg_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      go_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          oeas_pkg::CFG_RATE:   cur_rate_q <= cfg_data_i;
          oeas_pkg::CFG_MINCUT: min_cut_q  <= cfg_data_i;
          oeas_pkg::CFG_BETA:   beta_q     <= cfg_data_i;
          oeas_pkg::CFG_DCUT:   dcut_q     <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_q          <= {in_ch.sample, 8'd0};
            dt_q         <= dt_new;
            prev_stamp_q <= in_ch.stamp_us;
            prev_sv_q    <= in_ch.stamp_valid;
            if (upd) begin
              state_q <= S_RATE;
              go_q    <= 1'b1;
            end else if (vprim_q) begin
              state_q <= S_DMUL;
              go_q    <= 1'b1;
            end else begin
              d_q     <= '0;
              state_q <= S_DFIL;
            end
          end
        end
        S_RATE: begin
          if (div_rsp.done) begin
            cur_rate_q <= rsat;
            if (vprim_q) begin
              state_q <= S_DMUL;
              go_q    <= 1'b1;
            end else begin
              d_q     <= '0;
              state_q <= S_DFIL;
            end
          end
        end
        S_DMUL: begin
          if (mul_rsp.done) begin
            d_q     <= dval;
            state_q <= S_DFIL;
          end
        end
        S_DFIL: begin
          if (dprim_q) begin
            stage_q <= 1'b0;
            fc_q    <= dcut_q;
            state_q <= S_WMUL;
          end else begin
            dstate_q <= d_q;
            dprim_q  <= 1'b1;
            state_q  <= S_CMUL;
          end
          go_q <= 1'b1;
        end
        S_WMUL: begin
          if (go_q) begin
            bmag_q <= babs[31:0];
            bneg_q <= bdiff[32];
          end
          if (mul_rsp.done) begin
            w_q     <= w_new;
            den_q   <= den_new;
            state_q <= S_ADIV;
            go_q    <= 1'b1;
          end
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            alpha_q <= div_rsp.quot[16:0];
            state_q <= S_BMUL;
            go_q    <= 1'b1;
          end
        end
        S_BMUL: begin
          if (mul_rsp.done) begin
            if (stage_q) begin
              vstate_q <= bnew[23:0];
              state_q  <= S_OUT;
            end else begin
              dstate_q <= bnew[31:0];
              state_q  <= S_CMUL;
              go_q     <= 1'b1;
            end
          end
        end
        S_CMUL: begin
          if (mul_rsp.done) begin
            fc_q <= csat;
            if (vprim_q) begin
              stage_q <= 1'b1;
              state_q <= S_WMUL;
              go_q    <= 1'b1;
            end else begin
              vstate_q <= x_q;
              vprim_q  <= 1'b1;
              state_q  <= S_OUT;
            end
          end
        end
        S_OUT: begin
          // The output register is free or is being emptied in this cycle.
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= vstate_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready     = (state_q == S_IDLE);
  assign out_ch.valid    = out_valid_q;
  assign out_ch.smoothed = out_data_q;

`ifndef ASSERT_OFF
  a_mul_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_units_quiet_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mul_rsp.busy && !div_rsp.busy))
    else $error("serial unit busy while waiting for input");

  a_primed_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(vprim_q) && !$fell(dprim_q))
    else $error("filter primed flag cleared outside reset");
`endif

endmodule

>>> sv/oeas_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module oeas_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oeas_pkg::mul_req_t req_i,
  output oeas_pkg::mul_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [oeas_pkg::MulCntW-1:0]  cnt_q;
  logic [oeas_pkg::MulAW-1:0]    a_q;
  logic [oeas_pkg::ProdW-1:0]    prod_q;
  logic [oeas_pkg::ProdW-1:0]    prod_d;
  logic [oeas_pkg::MulAW:0]      sum;

  // Add the multiplicand into the high half when the current low bit is set.
  assign sum = {1'b0, prod_q[oeas_pkg::ProdW-1:oeas_pkg::MulBW]}
             + (prod_q[0] ? {1'b0, a_q} : {(oeas_pkg::MulAW+1){1'b0}});
  assign prod_d = {sum, prod_q[oeas_pkg::MulBW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == oeas_pkg::MulCntW'(oeas_pkg::MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q    <= req_i.a;
      prod_q <= {{oeas_pkg::MulAW{1'b0}}, req_i.b};
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = prod_q;

endmodule

>>> sv/oeas_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module oeas_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oeas_pkg::div_req_t req_i,
  output oeas_pkg::div_rsp_t rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [oeas_pkg::DivCntW-1:0]  cnt_q;
  logic [oeas_pkg::DivCntW-1:0]  steps_q;
  logic [oeas_pkg::DivRemW-1:0]  rem_q;
  logic [oeas_pkg::DivRemW-1:0]  den_q;
  logic [oeas_pkg::DivLowW-1:0]  low_q;
  logic [oeas_pkg::DivRemW:0]    shifted;
  logic [oeas_pkg::DivRemW:0]    diff;
  logic                          ge;

  // The remainder stays below the divisor, so its top bit is always clear.
  assign shifted = {rem_q, low_q[oeas_pkg::DivLowW-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == steps_q - 1'b1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q   <= req_i.rem;
      low_q   <= req_i.low;
      den_q   <= req_i.den;
      steps_q <= req_i.steps;
    end else if (busy_q) begin
      rem_q <= ge ? diff[oeas_pkg::DivRemW-1:0] : shifted[oeas_pkg::DivRemW-1:0];
      low_q <= {low_q[oeas_pkg::DivLowW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule

>>> test/testbench.sv
// Self-checking testbench for the one-euro adaptive smoother.
`timescale 1ns / 1ps
module testbench;

  // Clock, reset and register write stimulus.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = 2'd0;
  logic [23:0] cfg_data_i = 24'd0;

  oeas_in_if in_ch ();
  oeas_out_if out_ch ();

  one_euro_adaptive_smoother dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // The clock has a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state, kept at the block's widths plus headroom for intermediate values.
  logic [23:0] pr_rate_reg, pr_mincut, pr_beta, pr_dcut;
  logic [23:0] pr_rate;
  logic [31:0] pr_stamp;
  bit          pr_stamp_ok, pr_val_primed, pr_der_primed;
  longint      pr_value, pr_deriv;

  // Expected smoothed values, oldest first.
  logic [23:0] smoothed_q[$];
  int errors = 0;
  int sent = 0;
  int got = 0;
  bit no_idle = 1'b0;

  function automatic longint unsigned cutoff_alpha(longint unsigned fc, longint unsigned rate);
    longint unsigned w, d;
    w = (fc * 64'd105414357) >> 16;
    d = w + (rate << 16);
    return ((w << 16) + d / 2) / d;
  endfunction

  function automatic longint lowpass(longint s, longint v, longint unsigned a);
    longint diff;
    longint unsigned mag, q;
    diff = v - s;
    mag = diff < 0 ? longint'(-diff) : diff;
    q = (mag >> 16) * a + (((mag & 64'hFFFF) * a + 64'h8000) >> 16);
    return diff < 0 ? s - longint'(q) : s + longint'(q);
  endfunction

  task automatic smoother_reset();
    pr_rate_reg = 24'd30720;
    pr_mincut = 24'd65536;
    pr_beta = 24'd459;
    pr_dcut = 24'd65536;
    pr_rate = pr_rate_reg;
    pr_stamp = '0;
    pr_stamp_ok = 1'b0;
    pr_val_primed = 1'b0;
    pr_der_primed = 1'b0;
    pr_value = 0;
    pr_deriv = 0;
  endtask

  // Works out the smoothed value for one sample and advances the predictor.
  function automatic logic [23:0] smooth_sample(logic signed [15:0] smp, logic [31:0] stamp,
                                                bit stamp_ok);
    logic [31:0] dt;
    longint unsigned r, rate, dm, q, mag, cut;
    longint x, dv, diff;
    dv = 0;
    x = longint'(smp) * 256;
    if (stamp_ok && pr_stamp_ok) begin
      dt = stamp - pr_stamp;
      if (dt != 0) begin
        r = (64'd256000000 + dt / 2) / dt;
        if (r > 64'hFFFFFF) r = 64'hFFFFFF;
        if (r < 1) r = 1;
        pr_rate = r[23:0];
      end
    end
    pr_stamp = stamp;
    pr_stamp_ok = stamp_ok;
    rate = pr_rate == 0 ? 1 : pr_rate;
    if (pr_val_primed) begin
      diff = x - pr_value;
      dm = diff < 0 ? longint'(-diff) : diff;
      if (dm >= (64'd1 << 40)) q = 64'h7FFFFFFF;
      else begin
        q = (dm * rate + 128) >> 8;
        if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      end
      dv = diff < 0 ? -longint'(q) : longint'(q);
    end
    if (pr_der_primed) pr_deriv = lowpass(pr_deriv, dv, cutoff_alpha(pr_dcut, rate));
    else begin
      pr_deriv = dv;
      pr_der_primed = 1'b1;
    end
    mag = pr_deriv < 0 ? longint'(-pr_deriv) : pr_deriv;
    cut = pr_mincut + ((pr_beta * mag) >> 8);
    if (cut > 64'hFFFFFF) cut = 64'hFFFFFF;
    if (pr_val_primed) pr_value = lowpass(pr_value, x, cutoff_alpha(cut, rate));
    else begin
      pr_value = x;
      pr_val_primed = 1'b1;
    end
    return pr_value[23:0];
  endfunction

  // One transfer on in_ch; the expectation is queued when the transfer happens.
  // A directed row may carry a literal expectation that is checked against the predictor too.
  // Valid stays high after the transfer; the next idle cycle or drain() lowers it.
  task automatic send_sample(logic signed [15:0] smp, logic [31:0] stamp, bit stamp_ok,
                             bit has_lit, logic [23:0] lit);
    logic [23:0] exp_val;
    while (!no_idle && $urandom_range(99) < 22) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= smp;
    in_ch.stamp_us <= stamp;
    in_ch.stamp_valid <= stamp_ok;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    exp_val = smooth_sample(smp, stamp, stamp_ok);
    if (has_lit && lit !== exp_val) begin
      $display("%0t: table row disagrees: expected %h, predicted %h", $time, lit, exp_val);
      errors++;
    end
    smoothed_q.push_back(exp_val);
    sent++;
  endtask

  // The sink side: random back-pressure, and each transfer is matched against the oldest entry.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        got++;
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_ch.smoothed);
          errors++;
        end else begin
          if (out_ch.smoothed !== smoothed_q[0]) begin
            $display("%0t: smoothed mismatch: expected %h, actual %h",
                     $time, smoothed_q[0], out_ch.smoothed);
            errors++;
          end
          void'(smoothed_q.pop_front());
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // Drives one register write; the caller lowers the write enable after the last one.
  task automatic write_reg(oeas_pkg::cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      oeas_pkg::CFG_RATE: begin
        pr_rate_reg = val;
        pr_rate = val;
      end
      oeas_pkg::CFG_MINCUT: pr_mincut = val;
      oeas_pkg::CFG_BETA: pr_beta = val;
      default: pr_dcut = val;
    endcase
  endtask

  // Waits until every expected result is in, with a margin of the per-item latency.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  typedef struct {
    logic signed [15:0] smp;
    logic [31:0] stamp;
    bit stamp_ok;
    bit has_lit;
    logic [23:0] lit;
  } stim_row_t;

  // Directed rows: first sample passes through, extremes, missing, equal and wrapping stamps.
  stim_row_t stim_table[] = '{
    '{16'sh7FFF, 32'd0, 1'b1, 1'b1, 24'h7FFF00},
    '{16'sh7FFF, 32'd1000, 1'b1, 1'b1, 24'h7FFF00},
    '{-16'sh8000, 32'd2000, 1'b1, 1'b0, 24'h0},
    '{-16'sh8000, 32'd2000, 1'b1, 1'b0, 24'h0},
    '{16'sh0000, 32'hFFFFFFFF, 1'b1, 1'b0, 24'h0},
    '{16'sh7FFF, 32'h00000003, 1'b1, 1'b0, 24'h0},
    '{-16'sh8000, 32'h12345678, 1'b0, 1'b0, 24'h0},
    '{16'sh1234, 32'hABCDEF01, 1'b1, 1'b0, 24'h0},
    '{16'sh5555, 32'hABCDEF02, 1'b1, 1'b0, 24'h0},
    '{-16'sh5556, 32'hAAAAAAAA, 1'b1, 1'b0, 24'h0},
    '{16'sh0001, 32'h55555555, 1'b1, 1'b0, 24'h0},
    '{-16'sh0001, 32'h55555555, 1'b0, 1'b0, 24'h0},
    '{16'sh0000, 32'h00000000, 1'b0, 1'b0, 24'h0}
  };

  // Register settings for the phases: all zero, all ones, the defaults with a rate of 256, then random values.
  task automatic load_phase(int ph);
    case (ph)
      0: begin
        write_reg(oeas_pkg::CFG_RATE, 24'd0);
        write_reg(oeas_pkg::CFG_MINCUT, 24'd0);
        write_reg(oeas_pkg::CFG_BETA, 24'd0);
        write_reg(oeas_pkg::CFG_DCUT, 24'd0);
      end
      1: begin
        write_reg(oeas_pkg::CFG_RATE, 24'hFFFFFF);
        write_reg(oeas_pkg::CFG_MINCUT, 24'hFFFFFF);
        write_reg(oeas_pkg::CFG_BETA, 24'hFFFFFF);
        write_reg(oeas_pkg::CFG_DCUT, 24'hFFFFFF);
      end
      2: begin
        write_reg(oeas_pkg::CFG_RATE, 24'd256);
        write_reg(oeas_pkg::CFG_MINCUT, 24'd65536);
        write_reg(oeas_pkg::CFG_BETA, 24'd459);
        write_reg(oeas_pkg::CFG_DCUT, 24'd65536);
      end
      default: begin
        write_reg(oeas_pkg::CFG_RATE, 24'($urandom_range(24'hFFFFFF, 1)));
        write_reg(oeas_pkg::CFG_MINCUT, 24'($urandom_range(24'h3FFFFF)));
        write_reg(oeas_pkg::CFG_BETA, 24'($urandom_range(24'hFFFF)));
        write_reg(oeas_pkg::CFG_DCUT, 24'($urandom_range(24'h3FFFFF)));
      end
    endcase
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] clock_us;
    logic signed [15:0] level;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.stamp_us = '0;
    in_ch.stamp_valid = 1'b0;
    smoother_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part runs with register defaults straight out of reset.
    foreach (stim_table[i])
      send_sample(stim_table[i].smp, stim_table[i].stamp, stim_table[i].stamp_ok,
                  stim_table[i].has_lit, stim_table[i].lit);

    // Random phases. Most items are a plausible sensor stream with advancing stamps;
    // the rest are jumps, missing stamps and wild values.
    clock_us = $urandom;
    level = 16'($urandom);
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      load_phase(ph);
      if (ph == 5) no_idle = 1'b1;
      if (ph == 6) no_idle = 1'b0;
      for (int k = 0; k < 136; k++) begin
        if ($urandom_range(9) < 8) begin
          clock_us = clock_us + $urandom_range(20000, 0);
          level = level + $signed(16'($urandom_range(400))) - 16'sd200;
          send_sample(level, clock_us, $urandom_range(19) != 0, 1'b0, 24'h0);
        end else begin
          level = 16'($urandom);
          send_sample(level, $urandom, 1'($urandom_range(1)), 1'b0, 24'h0);
        end
      end
    end
    drain();

    $display("Covered %0d sample transfers and %0d results over nine register settings,",
             sent, got);
    $display("including extreme registers, zero rate and wrapping or missing timestamps.");
    if (errors == 0 && smoothed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // The timeout covers about 1100 items at the slowest per-item case, plus stalls.
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
